// ===== hdl/ptb_pkg.sv =====
package ptb_pkg;

  localparam int MAX_CHANNELS = 16;
  localparam int MAX_GROUPS   = 8;
  localparam int CH_W         = $clog2(MAX_CHANNELS);
  localparam int GR_W         = $clog2(MAX_GROUPS);
  localparam int ADDR_W       = CH_W + GR_W;
  localparam int DEPTH        = MAX_CHANNELS * MAX_GROUPS;

  localparam logic [31:0] ONE_Q16      = 32'd65536;
  localparam logic [31:0] TENTH_Q16    = 32'd6554;
  localparam logic [16:0] PROGRESS_MAX = 17'h1FFFF;
  localparam logic [4:0]  DIV_LAST     = 5'd16;

  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_START  = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;
  localparam logic [1:0] CMD_RSTDUR = 2'd3;

  localparam logic CFG_CHANNELS = 1'b0;
  localparam logic CFG_GROUPS   = 1'b1;

  typedef struct packed {
    logic        free;
    logic [31:0] elapsed;
    logic [31:0] duration;
    logic [16:0] progress;
  } entry_t;

  localparam entry_t ENTRY_CLEAR = '{free: 1'b1, elapsed: 32'd0, duration: 32'd0,
                                     progress: 17'd0};

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

endpackage

// ===== hdl/ptb_mem.sv =====
module ptb_mem (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr_en,
  input  logic [ptb_pkg::ADDR_W-1:0] wr_addr,
  input  ptb_pkg::entry_t            wr_data,
  input  logic                       rd_en,
  input  logic [ptb_pkg::ADDR_W-1:0] rd_addr,
  output ptb_pkg::entry_t            rd_data
);

  ptb_pkg::entry_t                  mem [ptb_pkg::DEPTH];
  logic [ptb_pkg::DEPTH-1:0]        valid_r;
  ptb_pkg::entry_t                  rd_data_r;
  logic                             rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Entries never written since reset read back as a cleared timer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid_r ? rd_data_r : ptb_pkg::ENTRY_CLEAR;

endmodule

// ===== hdl/ptb_div.sv =====
module ptb_div (
  input  logic              clk,
  input  logic              rst_n,
  input  ptb_pkg::div_req_t req,
  output logic              done,
  output logic [16:0]       quotient
);

  // Restoring division of (dividend << 16) by divisor, one quotient bit per
  // cycle. The caller guarantees the quotient fits in 17 bits.
  logic [31:0] rem_r;
  logic [31:0] div_r;
  logic        lsb_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [16:0] q_r;
  logic [32:0] trial;
  logic        fill;

  always_comb begin
    fill  = (cnt_r == '0) ? lsb_r : 1'b0;
    trial = {rem_r, fill};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == ptb_pkg::DIV_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= {1'b0, req.dividend[31:1]};
      lsb_r <= req.dividend[0];
      div_r <= req.divisor;
      q_r   <= '0;
    end else if (busy_r) begin
      if (trial >= {1'b0, div_r}) begin
        rem_r <= 32'(trial - {1'b0, div_r});
        q_r   <= {q_r[15:0], 1'b1};
      end else begin
        rem_r <= trial[31:0];
        q_r   <= {q_r[15:0], 1'b0};
      end
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// ===== hdl/progress_timer_bank.sv =====
// Bank of 16 x 8 one-shot progress timers held in one synchronous memory.
// A start command is handled in the idle state. An out-of-range query passes
// through S_QOUT and an in-range query through S_QRD and S_QOUT, where it waits on
// the result channel. A tick or a reset-durations command walks all 128 entries:
// an entry outside the active area is skipped in S_WALK, one that is idle, expires
// or saturates (and every in-area entry of a reset-durations walk) is read in
// S_WALK and handled in S_EVAL, and one that needs its progress recomputed waits
// in S_DIV for the one-bit-per-cycle divider.
// No new transaction is accepted while a command is in progress.
module progress_timer_bank (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // command[1:0], channel_index[9:2], group_index[17:10], time_value[49:18]
  input  logic [55:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // is_free[0], progress[17:1], duration_out[49:18]
  output logic [55:0] out_tdata
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WALK = 3'd1;
  localparam logic [2:0] S_EVAL = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_QRD  = 3'd4;
  localparam logic [2:0] S_QOUT = 3'd5;

  logic [2:0]  state_r, state_nxt;
  logic [4:0]  chan_cfg_r;
  logic [3:0]  grp_cfg_r;
  logic [4:0]  nc;
  logic [3:0]  ng;

  logic [ptb_pkg::ADDR_W-1:0] idx_r, idx_nxt;
  logic        rstdur_r, rstdur_nxt;
  logic [31:0] step_r, step_nxt;
  logic [31:0] el_r, el_nxt;
  logic        oor_r, oor_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [55:0] out_data_r, out_data_nxt;

  logic [1:0]  in_cmd;
  logic [7:0]  in_ch, in_gr;
  logic [31:0] in_time;
  logic        in_acc, in_area, idx_area, idx_last;

  logic                       mem_we, mem_re;
  logic [ptb_pkg::ADDR_W-1:0] mem_waddr, mem_raddr;
  ptb_pkg::entry_t            mem_wdata, mem_rdata;

  ptb_pkg::div_req_t div_req;
  logic              div_done;
  logic [16:0]       div_q;

  logic [32:0] sum;
  logic [31:0] el_new;
  logic        expire, sat;

  assign in_cmd  = in_tdata[1:0];
  assign in_ch   = in_tdata[9:2];
  assign in_gr   = in_tdata[17:10];
  assign in_time = in_tdata[49:18];

  assign nc = (chan_cfg_r > 5'(ptb_pkg::MAX_CHANNELS)) ? 5'(ptb_pkg::MAX_CHANNELS) : chan_cfg_r;
  assign ng = (grp_cfg_r > 4'(ptb_pkg::MAX_GROUPS)) ? 4'(ptb_pkg::MAX_GROUPS) : grp_cfg_r;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_area   = ({1'b0, in_ch} < {4'd0, nc}) && ({1'b0, in_gr} < {5'd0, ng});
  assign idx_area  = ({1'b0, idx_r[ptb_pkg::ADDR_W-1:ptb_pkg::GR_W]} < nc)
                  && ({1'b0, idx_r[ptb_pkg::GR_W-1:0]} < ng);
  assign idx_last  = (idx_r == ptb_pkg::ADDR_W'(ptb_pkg::DEPTH - 1));

  // Elapsed saturates, and the expiry test adds the step once more to the saturated value.
  assign sum    = {1'b0, mem_rdata.elapsed} + {1'b0, step_r};
  assign el_new = sum[32] ? '1 : sum[31:0];
  assign expire = ({1'b0, el_new} + {1'b0, step_r}) > {1'b0, mem_rdata.duration};
  assign sat    = {1'b0, el_new} >= {mem_rdata.duration, 1'b0};

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    rstdur_nxt    = rstdur_r;
    step_nxt      = step_r;
    el_nxt        = el_r;
    oor_nxt       = oor_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = idx_r;
    mem_wdata     = mem_rdata;
    mem_re        = 1'b0;
    mem_raddr     = idx_r;
    div_req       = '{start: 1'b0, dividend: el_new, divisor: mem_rdata.duration};

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_cmd) inside
            ptb_pkg::CMD_TICK, ptb_pkg::CMD_RSTDUR: begin
              idx_nxt    = '0;
              step_nxt   = in_time;
              rstdur_nxt = (in_cmd == ptb_pkg::CMD_RSTDUR);
              state_nxt  = S_WALK;
            end
            ptb_pkg::CMD_START: begin
              mem_we    = in_area;
              mem_waddr = {in_ch[ptb_pkg::CH_W-1:0], in_gr[ptb_pkg::GR_W-1:0]};
              mem_wdata = '{free: 1'b0, elapsed: 32'd0, progress: 17'd0,
                            duration: (in_time == '0) ? ptb_pkg::ONE_Q16 : in_time};
            end
            default: begin
              mem_re    = in_area;
              mem_raddr = {in_ch[ptb_pkg::CH_W-1:0], in_gr[ptb_pkg::GR_W-1:0]};
              oor_nxt   = !in_area;
              state_nxt = in_area ? S_QRD : S_QOUT;
            end
          endcase
        end
      end
      S_WALK: begin
        if (idx_area) begin
          mem_re    = 1'b1;
          state_nxt = S_EVAL;
        end else if (idx_last) begin
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_EVAL: begin
        state_nxt = idx_last ? S_IDLE : S_WALK;
        idx_nxt   = idx_r + 1'b1;
        if (rstdur_r) begin
          mem_we             = 1'b1;
          mem_wdata.duration = ptb_pkg::TENTH_Q16;
        end else if (!mem_rdata.free) begin
          if (expire) begin
            mem_we    = 1'b1;
            mem_wdata = ptb_pkg::ENTRY_CLEAR;
          end else if (sat) begin
            mem_we             = 1'b1;
            mem_wdata.elapsed  = el_new;
            mem_wdata.progress = ptb_pkg::PROGRESS_MAX;
          end else begin
            div_req.start = 1'b1;
            el_nxt        = el_new;
            idx_nxt       = idx_r;
            state_nxt     = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          mem_we             = 1'b1;
          mem_wdata.elapsed  = el_r;
          mem_wdata.progress = div_q;
          idx_nxt            = idx_r + 1'b1;
          state_nxt          = idx_last ? S_IDLE : S_WALK;
        end
      end
      S_QRD: begin
        state_nxt = S_QOUT;
      end
      S_QOUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          if (oor_r) begin
            out_data_nxt = {6'd0, ptb_pkg::ONE_Q16, ptb_pkg::ONE_Q16[16:0], 1'b0};
          end else begin
            out_data_nxt = {6'd0, mem_rdata.duration, mem_rdata.progress, mem_rdata.free};
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      chan_cfg_r  <= 5'(ptb_pkg::MAX_CHANNELS);
      grp_cfg_r   <= 4'(ptb_pkg::MAX_GROUPS);
      idx_r       <= '0;
      rstdur_r    <= 1'b0;
      oor_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
      rstdur_r    <= rstdur_nxt;
      oor_r       <= oor_nxt;
      if (cfg_wr_en) begin
        if (cfg_index == ptb_pkg::CFG_CHANNELS) begin
          chan_cfg_r <= cfg_wdata;
        end else begin
          grp_cfg_r <= cfg_wdata[3:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    step_r     <= step_nxt;
    el_r       <= el_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  ptb_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  ptb_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_q)
  );

endmodule
